// ----- rtl/rorl_pkg.sv -----
// Shared types, widths and parameter defaults for the relocating object record loader.
package rorl_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 24;
    localparam int DIGIT_W = 4;
    localparam int WADDR_W = 24;
    localparam int COUNT_W = 2;

    // Parameter defaults
    localparam int ADDR_BITS_DEF   = 24;
    localparam int RELOC_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    // One write job: up to three bytes, first byte in the top byte lane
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  data;
    } job_info_t;

endpackage

// ----- rtl/relocating_object_record_loader.sv -----
// Relocating object record loader: character parser, job queue and byte write sequencer.
// A write job passes through the queue registers, then the sequencer registers, before output.
// Throughput: one character per cycle while the queue has room; one byte write per cycle out
// while out_ready is high, so a character that completes a word makes three byte writes.
// Reset: line state returns to idle; start, offset, target and load address clear to zero; no clearing pass.
module relocating_object_record_loader #(
    parameter int ADDR_BITS   = rorl_pkg::ADDR_BITS_DEF,
    parameter int RELOC_BITS  = rorl_pkg::RELOC_BITS_DEF,
    parameter int QUEUE_DEPTH = rorl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [rorl_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rorl_pkg::BYTE_W-1:0]   char_code,
    input  logic                          line_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rorl_pkg::WADDR_W-1:0]  write_address,
    output logic [rorl_pkg::BYTE_W-1:0]   write_data,
    output logic                          last_write
);

    localparam int INFO_W = $bits(rorl_pkg::job_info_t);
    localparam int JOB_W  = ADDR_BITS + INFO_W;

    logic                 queue_full;
    logic                 job_push;
    logic [ADDR_BITS-1:0] job_addr;
    rorl_pkg::job_info_t  job_info;
    logic                 q_pop;
    logic                 q_valid;
    logic [JOB_W-1:0]     q_data;
    logic [ADDR_BITS-1:0] q_addr;
    rorl_pkg::job_info_t  q_info;

    assign q_addr = q_data[JOB_W-1 -: ADDR_BITS];
    assign q_info = q_data[INFO_W-1:0];

    rorl_front #(
        .ADDR_BITS  (ADDR_BITS),
        .RELOC_BITS (RELOC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .line_end   (line_end),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job_addr   (job_addr),
        .job_info   (job_info)
    );

    rorl_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .wr_data  ({job_addr, job_info}),
        .full     (queue_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    rorl_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_addr        (q_addr),
        .q_info        (q_info),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_data    (write_data),
        .last_write    (last_write)
    );

endmodule

// ----- rtl/rorl_queue.sv -----
// Short job queue between the record parser and the byte write sequencer.
module rorl_queue #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/rorl_front.sv -----
// Record parser: takes characters, tracks line state and forms byte write jobs.
module rorl_front #(
    parameter int ADDR_BITS  = rorl_pkg::ADDR_BITS_DEF,
    parameter int RELOC_BITS = rorl_pkg::RELOC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [rorl_pkg::WORD_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rorl_pkg::BYTE_W-1:0]  char_code,
    input  logic                         line_end,
    input  logic                         queue_full,
    output logic                         job_push,
    output logic [ADDR_BITS-1:0]         job_addr,
    output rorl_pkg::job_info_t          job_info
);

    localparam int WORD_W  = rorl_pkg::WORD_W;
    localparam int BYTE_W  = rorl_pkg::BYTE_W;
    localparam int DIGIT_W = rorl_pkg::DIGIT_W;
    localparam int COUNT_W = rorl_pkg::COUNT_W;
    localparam int OFS_W   = (ADDR_BITS > WORD_W) ? ADDR_BITS : WORD_W;
    localparam int RI_W    = $clog2(RELOC_BITS);
    localparam logic [4:0] RELOC_LIMIT = 5'(RELOC_BITS);

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_H  = 8'h48;
    localparam logic [BYTE_W-1:0] CHAR_T  = 8'h54;

    typedef enum logic [3:0] {
        KIND_NONE   = 4'b0001,
        KIND_HEADER = 4'b0010,
        KIND_TEXT   = 4'b0100,
        KIND_OTHER  = 4'b1000
    } kind_t;

    typedef enum logic [3:0] {
        PH_NAME   = 4'b0001,
        PH_GAP    = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    function automatic logic [DIGIT_W-1:0] hex_val(input logic [BYTE_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return c[DIGIT_W-1:0];
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return c[DIGIT_W-1:0] + 4'd9;
        end
        return '0;
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C;
    endfunction

    logic [3:0]             col_reg, col_next;
    kind_t                  kind_reg, kind_next;
    phase_t                 ph_reg, ph_next;
    logic [WORD_W-1:0]      load_reg, load_next;
    logic [WORD_W-1:0]      start_reg, start_next;
    logic [OFS_W-1:0]       ofs_reg, ofs_next;
    logic [ADDR_BITS-1:0]   tgt_reg, tgt_next;
    logic [RELOC_BITS-1:0]  mask_reg, mask_next;
    logic [WORD_W-1:0]      wacc_reg, wacc_next;
    logic [2:0]             dc_reg, dc_next;
    logic [3:0]             wi_reg, wi_next;
    logic                   accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign job_push = accept && (job_info.count != '0);

    // Parse one character and form its write job
    always_comb
    begin
        logic [DIGIT_W-1:0]    h;
        logic                  sp;
        logic [WORD_W-1:0]     acc_sh;
        logic [2:0]            dc_inc;
        logic                  do_commit;
        logic [ADDR_BITS-1:0]  tgt_sh;
        logic                  rel;
        logic [WORD_W-1:0]     word;
        logic [RELOC_BITS-1:0] mask_rev;

        h         = hex_val(char_code);
        sp        = is_space(char_code);
        acc_sh    = WORD_W'({wacc_reg, h});
        dc_inc    = dc_reg + 3'd1;
        tgt_sh    = ADDR_BITS'({tgt_reg, h});
        do_commit = 1'b0;
        for (int i = 0; i < RELOC_BITS; i++)
        begin
            mask_rev[i] = mask_reg[RELOC_BITS-1-i];
        end
        rel  = ({1'b0, wi_reg} < RELOC_LIMIT) && mask_rev[wi_reg[RI_W-1:0]];
        word = rel ? acc_sh + ofs_reg[WORD_W-1:0] : acc_sh;

        col_next   = col_reg;
        kind_next  = kind_reg;
        ph_next    = ph_reg;
        start_next = start_reg;
        tgt_next   = tgt_reg;
        mask_next  = mask_reg;
        wacc_next  = wacc_reg;
        dc_next    = dc_reg;
        wi_next    = wi_reg;
        load_next  = cfg_wen ? cfg_wdata : load_reg;
        job_addr   = tgt_reg;
        job_info   = '0;

        if (accept)
        begin
            if (char_code != CHAR_CR)
            begin
                if (col_reg == 4'd0)
                begin
                    // Open a new line by its record letter
                    wacc_next = '0;
                    dc_next   = '0;
                    wi_next   = '0;
                    ph_next   = PH_NAME;
                    if (char_code == CHAR_H)
                    begin
                        kind_next = KIND_HEADER;
                    end
                    else if (char_code == CHAR_T)
                    begin
                        kind_next = KIND_TEXT;
                        tgt_next  = '0;
                        mask_next = '0;
                    end
                    else
                    begin
                        kind_next = KIND_OTHER;
                    end
                end
                else if (kind_reg == KIND_HEADER)
                begin
                    // Walk name, gap and start digits
                    unique case (ph_reg)
                        PH_NAME:
                        begin
                            if (sp)
                            begin
                                ph_next = PH_GAP;
                            end
                        end
                        PH_GAP:
                        begin
                            if (!sp)
                            begin
                                ph_next   = PH_DIGITS;
                                wacc_next = WORD_W'(h);
                                dc_next   = 3'd1;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (sp)
                            begin
                                do_commit = 1'b1;
                            end
                            else
                            begin
                                wacc_next = acc_sh;
                                dc_next   = dc_inc;
                                do_commit = (dc_inc >= 3'd6);
                            end
                        end
                        PH_DONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                    if (do_commit)
                    begin
                        if (dc_next != '0)
                        begin
                            start_next = wacc_next;
                        end
                        wacc_next = '0;
                        dc_next   = '0;
                        ph_next   = PH_DONE;
                    end
                end
                else if (kind_reg == KIND_TEXT)
                begin
                    if (col_reg >= 4'd1 && col_reg <= 4'd6)
                    begin
                        // Shift in the target address, relocate on its last digit
                        tgt_next = (col_reg == 4'd6) ? tgt_sh + ADDR_BITS'(ofs_reg) : tgt_sh;
                    end
                    else if (col_reg >= 4'd9 && col_reg <= 4'd11)
                    begin
                        mask_next = RELOC_BITS'({mask_reg, h});
                    end
                    else if (col_reg >= 4'd12)
                    begin
                        if (dc_inc >= 3'd6)
                        begin
                            // Complete word: issue three bytes
                            job_addr       = tgt_reg;
                            job_info.count = COUNT_W'(3);
                            job_info.data  = word;
                            tgt_next       = tgt_reg + ADDR_BITS'(3);
                            wacc_next      = '0;
                            dc_next        = '0;
                            wi_next        = (wi_reg == 4'hF) ? wi_reg : wi_reg + 4'd1;
                        end
                        else
                        begin
                            wacc_next = acc_sh;
                            dc_next   = dc_inc;
                        end
                    end
                end
                col_next = (col_reg == 4'hF) ? col_reg : col_reg + 4'd1;
            end

            if (line_end)
            begin
                // Close the start field or flush leftover byte pairs
                if (kind_next == KIND_HEADER && ph_next == PH_DIGITS && dc_next != '0)
                begin
                    start_next = wacc_next;
                end
                if (kind_next == KIND_TEXT && dc_next >= 3'd2)
                begin
                    job_addr = tgt_next;
                    case (dc_next)
                        3'd2:
                        begin
                            job_info.count = COUNT_W'(1);
                            job_info.data  = {wacc_next[7:0], 16'h0000};
                        end
                        3'd3:
                        begin
                            job_info.count = COUNT_W'(1);
                            job_info.data  = {wacc_next[11:4], 16'h0000};
                        end
                        3'd4:
                        begin
                            job_info.count = COUNT_W'(2);
                            job_info.data  = {wacc_next[15:8], wacc_next[7:0], 8'h00};
                        end
                        3'd5:
                        begin
                            job_info.count = COUNT_W'(2);
                            job_info.data  = {wacc_next[19:12], wacc_next[11:4], 8'h00};
                        end
                        default:
                        begin
                        end
                    endcase
                    tgt_next = tgt_next + ADDR_BITS'(job_info.count);
                end
                col_next  = '0;
                kind_next = KIND_NONE;
                ph_next   = PH_NAME;
                wacc_next = '0;
                dc_next   = '0;
                wi_next   = '0;
            end
        end

        // Keep the relocation offset in step with load and start
        ofs_next = OFS_W'(load_next) - OFS_W'(start_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            kind_reg  <= KIND_NONE;
            ph_reg    <= PH_NAME;
            load_reg  <= '0;
            start_reg <= '0;
            ofs_reg   <= '0;
            tgt_reg   <= '0;
            mask_reg  <= '0;
            wacc_reg  <= '0;
            dc_reg    <= '0;
            wi_reg    <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            kind_reg  <= kind_next;
            ph_reg    <= ph_next;
            load_reg  <= load_next;
            start_reg <= start_next;
            ofs_reg   <= ofs_next;
            tgt_reg   <= tgt_next;
            mask_reg  <= mask_next;
            wacc_reg  <= wacc_next;
            dc_reg    <= dc_next;
            wi_reg    <= wi_next;
        end
    end

endmodule

// ----- rtl/rorl_back.sv -----
// Byte write sequencer: pops write jobs and issues one byte write per cycle while out_ready is high.
module rorl_back #(
    parameter int ADDR_BITS = rorl_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [ADDR_BITS-1:0]          q_addr,
    input  rorl_pkg::job_info_t           q_info,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rorl_pkg::WADDR_W-1:0]  write_address,
    output logic [rorl_pkg::BYTE_W-1:0]   write_data,
    output logic                          last_write
);

    localparam int WA_W    = rorl_pkg::WADDR_W;
    localparam int WORD_W  = rorl_pkg::WORD_W;
    localparam int BYTE_W  = rorl_pkg::BYTE_W;
    localparam int COUNT_W = rorl_pkg::COUNT_W;

    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [WORD_W-1:0]    data_reg, data_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic                 take;
    logic                 free;

    assign out_valid     = (rem_reg != '0);
    assign last_write    = (rem_reg == COUNT_W'(1));
    assign write_address = WA_W'(addr_reg);
    assign write_data    = data_reg[WORD_W-1 -: BYTE_W];
    assign take          = out_valid && out_ready;
    assign free          = !out_valid || (take && last_write);
    assign q_pop         = free && q_valid;

    // Load the next job or advance through the current one
    always_comb
    begin
        addr_next = addr_reg;
        data_next = data_reg;
        rem_next  = rem_reg;
        if (q_pop)
        begin
            addr_next = q_addr;
            data_next = q_info.data;
            rem_next  = q_info.count;
        end
        else if (take)
        begin
            addr_next = addr_reg + ADDR_BITS'(1);
            data_next = {data_reg[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            rem_next  = rem_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    // Hold payload of the byte on offer
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        data_reg <= data_next;
    end

endmodule

// ----- tb/rorl_write_checker.sv -----
// Write predictor and checker for the relocating object record loader.
`timescale 1ns / 1ps

module rorl_write_checker #(
    parameter int RELOC_BITS = rorl_pkg::RELOC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [rorl_pkg::WORD_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [rorl_pkg::BYTE_W-1:0]  char_code,
    input  logic                         line_end,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [rorl_pkg::WADDR_W-1:0] write_address,
    input  logic [rorl_pkg::BYTE_W-1:0]  write_data,
    input  logic                         last_write,
    output int                           mismatches,
    output int                           writes_pending,
    output int                           writes_checked
);

    typedef enum logic [1:0] {KIND_NONE, KIND_HEADER, KIND_TEXT, KIND_OTHER} record_kind_t;
    typedef enum logic [1:0] {PH_NAME, PH_GAP, PH_DIGITS, PH_DONE} header_phase_t;

    typedef struct packed {
        logic [rorl_pkg::WADDR_W-1:0] addr;
        logic [rorl_pkg::BYTE_W-1:0]  data;
        logic                         last;
    } byte_write_t;

    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_H  = "H";
    localparam logic [7:0] CHR_T  = "T";
    localparam int REPORT_MAX = 10;

    // Loader state as the parser sees it
    logic [23:0]           load_addr;
    logic [3:0]            col_q;
    record_kind_t          kind_q;
    header_phase_t         phase_q;
    logic [23:0]           start_q;
    logic [27:0]           target_q;
    logic [RELOC_BITS-1:0] mask_q;
    logic [23:0]           acc_q;
    logic [2:0]            ndig_q;
    logic [3:0]            widx_q;

    byte_write_t pending_writes[$];
    int          fail_count;
    int          good_count;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - "0");
        end
        if (c >= "A" && c <= "F")
        begin
            return 4'(c - "A" + 8'd10);
        end
        if (c >= "a" && c <= "f")
        begin
            return 4'(c - "a" + 8'd10);
        end
        return 4'h0;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C;
    endfunction

    // Relocation offset from the current load address and program start
    function automatic logic [23:0] reloc_offset();
        return load_addr - start_q;
    endfunction

    // Queue one byte write and advance the target address
    task automatic store_byte(input logic [7:0] d);
        pending_writes.insert(pending_writes.size(), {target_q[23:0], d, 1'b0});
        target_q = {4'h0, target_q[23:0] + 24'd1};
    endtask

    task automatic commit_start();
        if (ndig_q != 3'd0)
        begin
            start_q = acc_q;
        end
        acc_q   = '0;
        ndig_q  = '0;
        phase_q = PH_DONE;
    endtask

    // Header record: name token, blanks, then up to six start digits
    task automatic header_char(input logic [7:0] c);
        case (phase_q)
            PH_NAME:
            begin
                if (is_blank(c))
                begin
                    phase_q = PH_GAP;
                end
            end
            PH_GAP:
            begin
                if (!is_blank(c))
                begin
                    phase_q = PH_DIGITS;
                    acc_q   = {20'h0, hex_value(c)};
                    ndig_q  = 3'd1;
                end
            end
            PH_DIGITS:
            begin
                if (is_blank(c))
                begin
                    commit_start();
                end
                else
                begin
                    acc_q  = {acc_q[19:0], hex_value(c)};
                    ndig_q = ndig_q + 3'd1;
                    if (ndig_q >= 3'd6)
                    begin
                        commit_start();
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Text record: address, ignored length, mask, then six-digit words
    task automatic text_char(input logic [3:0] col, input logic [7:0] c);
        logic [3:0]  h;
        logic [23:0] w;
        int          wi;
        h  = hex_value(c);
        wi = int'(widx_q);
        if (col >= 4'd1 && col <= 4'd6)
        begin
            target_q = {target_q[23:0], h};
            if (col == 4'd6)
            begin
                target_q = {4'h0, target_q[23:0] + reloc_offset()};
            end
        end
        else if (col >= 4'd9 && col <= 4'd11)
        begin
            mask_q = (mask_q << 4) | h;
        end
        else if (col >= 4'd12)
        begin
            acc_q  = {acc_q[19:0], h};
            ndig_q = ndig_q + 3'd1;
            if (ndig_q >= 3'd6)
            begin
                w = acc_q;
                if (wi < RELOC_BITS && mask_q[RELOC_BITS-1-wi])
                begin
                    w = w + reloc_offset();
                end
                store_byte(w[23:16]);
                store_byte(w[15:8]);
                store_byte(w[7:0]);
                acc_q  = '0;
                ndig_q = '0;
                if (widx_q != 4'd15)
                begin
                    widx_q = widx_q + 4'd1;
                end
            end
        end
    endtask

    // Advance the parser by one character and queue the writes it causes
    task automatic parse_char(input logic [7:0] c, input logic e);
        int          before_n;
        int          pairs;
        int          sh;
        byte_write_t tail;
        before_n = pending_writes.size();
        if (c != CHR_CR)
        begin
            if (col_q == 4'd0)
            begin
                acc_q   = '0;
                ndig_q  = '0;
                widx_q  = '0;
                phase_q = PH_NAME;
                if (c == CHR_H)
                begin
                    kind_q = KIND_HEADER;
                end
                else if (c == CHR_T)
                begin
                    kind_q   = KIND_TEXT;
                    target_q = '0;
                    mask_q   = '0;
                end
                else
                begin
                    kind_q = KIND_OTHER;
                end
            end
            else if (kind_q == KIND_HEADER)
            begin
                header_char(c);
            end
            else if (kind_q == KIND_TEXT)
            begin
                text_char(col_q, c);
            end
            if (col_q != 4'd15)
            begin
                col_q = col_q + 4'd1;
            end
        end
        if (e)
        begin
            if (kind_q == KIND_HEADER && phase_q == PH_DIGITS)
            begin
                commit_start();
            end
            // Flush whole byte pairs of an unfinished word
            if (kind_q == KIND_TEXT && ndig_q >= 3'd2)
            begin
                pairs = int'(ndig_q) / 2;
                for (int k = 0; k < pairs; k++)
                begin
                    sh = 4 * (int'(ndig_q) - 2 - 2 * k);
                    store_byte(8'(acc_q >> sh));
                end
            end
            col_q   = '0;
            kind_q  = KIND_NONE;
            phase_q = PH_NAME;
            acc_q   = '0;
            ndig_q  = '0;
            widx_q  = '0;
        end
        if (pending_writes.size() > before_n)
        begin
            tail      = pending_writes.pop_back();
            tail.last = 1'b1;
            pending_writes.insert(pending_writes.size(), tail);
        end
    endtask

    // Follow config, input and output channels; compare each write in order
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        byte_write_t got;
        byte_write_t want;
        if (!rst_n)
        begin
            load_addr  = '0;
            start_q    = '0;
            target_q   = '0;
            mask_q     = '0;
            col_q      = '0;
            kind_q     = KIND_NONE;
            phase_q    = PH_NAME;
            acc_q      = '0;
            ndig_q     = '0;
            widx_q     = '0;
            fail_count = 0;
            good_count = 0;
            pending_writes.delete();
            mismatches     <= 0;
            writes_pending <= 0;
            writes_checked <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                load_addr = cfg_wdata;
            end
            if (in_valid && in_ready)
            begin
                parse_char(char_code, line_end);
            end
            if (out_valid && out_ready)
            begin
                got = {write_address, write_data, last_write};
                if (pending_writes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                    begin
                        $display("unexpected write: addr %06h data %02h last %0b",
                                 write_address, write_data, last_write);
                    end
                end
                else
                begin
                    want = pending_writes.pop_front();
                    good_count++;
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("write mismatch: expected addr %06h data %02h last %0b,",
                                     want.addr, want.data, want.last);
                            $display("                got      addr %06h data %02h last %0b",
                                     got.addr, got.data, got.last);
                        end
                    end
                end
            end
            mismatches     <= fail_count;
            writes_pending <= pending_writes.size();
            writes_checked <= good_count;
        end
    end

endmodule

// ----- tb/relocating_object_record_loader_tb.sv -----
// Stimulus, reset and verdict for the relocating object record loader.
`timescale 1ns / 1ps

module relocating_object_record_loader_tb;

    localparam int PHASE_ITEMS  = 46;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_CYCLES = 100;

    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_H  = "H";
    localparam logic [7:0] CHR_T  = "T";

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_wen   = 1'b0;
    logic [rorl_pkg::WORD_W-1:0]  cfg_wdata = '0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [rorl_pkg::BYTE_W-1:0]  char_code = '0;
    logic                         line_end  = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [rorl_pkg::WADDR_W-1:0] write_address;
    logic [rorl_pkg::BYTE_W-1:0]  write_data;
    logic                         last_write;

    int mismatches;
    int writes_pending;
    int writes_checked;

    int send_idle   = 0;
    int take_idle   = 0;
    int stall_epoch = 0;
    int stall_seen  = 0;
    int stall_left  = 0;
    int quiet_count = 0;
    int chars_sent  = 0;
    int lines_sent  = 0;
    int long_lines  = 0;

    logic [7:0] line_buf[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    relocating_object_record_loader u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .line_end      (line_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_data    (write_data),
        .last_write    (last_write)
    );

    rorl_write_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .write_address  (write_address),
        .write_data     (write_data),
        .last_write     (last_write),
        .mismatches     (mismatches),
        .writes_pending (writes_pending),
        .writes_checked (writes_checked)
    );

    // Drive the write-side ready: random stalls, or a long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            stall_seen <= 0;
        end
        else if (stall_seen != stall_epoch)
        begin
            stall_seen <= stall_epoch;
            stall_left <= STALL_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= take_idle);
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Append one character to the line being built
    task automatic append_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    // Offer one character and hold it until taken
    task automatic send_char(input logic [7:0] c, input logic e);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        line_end  <= e;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (c != CHR_CR)
        begin
            chars_sent++;
        end
    endtask

    task automatic send_string(input string s, input logic end_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], end_last && i == s.len() - 1);
        end
    endtask

    // Send the buffered line with stray carriage returns; mark its last item
    task automatic send_line();
        bit cr_end;
        cr_end = ($urandom_range(7) == 0);
        foreach (line_buf[i])
        begin
            if ($urandom_range(29) == 0)
            begin
                send_char(CHR_CR, 1'b0);
            end
            send_char(line_buf[i], !cr_end && i == line_buf.size() - 1);
        end
        if (cr_end)
        begin
            send_char(CHR_CR, 1'b1);
        end
        lines_sent++;
        line_buf.delete();
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(15);
        if ($urandom_range(24) == 0)
        begin
            return 8'($urandom_range(255));
        end
        if (v < 10)
        begin
            return 8'("0" + v);
        end
        if ($urandom_range(1) == 1)
        begin
            return 8'("a" + v - 10);
        end
        return 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(4))
            0:       return 8'h09;
            1:       return 8'h0A;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return " ";
        endcase
    endfunction

    // Append hex digits: mostly random, sometimes all ones or all zeros
    task automatic push_digits(input int n);
        int style;
        style = $urandom_range(9);
        repeat (n)
        begin
            case (style)
                0:       append_char("F");
                1:       append_char("0");
                default: append_char(rand_hex());
            endcase
        end
    endtask

    task automatic build_header();
        append_char(CHR_H);
        repeat ($urandom_range(5))
        begin
            append_char(8'("A" + $urandom_range(25)));
        end
        repeat ($urandom_range(1, 2))
        begin
            append_char(rand_blank());
        end
        push_digits(($urandom_range(3) == 0) ? $urandom_range(6) : 6);
        if ($urandom_range(3) == 0)
        begin
            append_char(" ");
            push_digits($urandom_range(4));
        end
    endtask

    task automatic build_text(input bit long_line);
        int words;
        append_char(CHR_T);
        push_digits(6);
        push_digits(2);
        push_digits(3);
        words = long_line ? $urandom_range(12, 15) : $urandom_range(4);
        if (long_line)
        begin
            long_lines++;
        end
        push_digits(6 * words + $urandom_range(5));
    endtask

    // Text record cut off at a random point
    task automatic build_broken_text();
        int keep;
        build_text(1'b0);
        keep = $urandom_range(1, line_buf.size());
        while (line_buf.size() > keep)
        begin
            void'(line_buf.pop_back());
        end
    endtask

    task automatic build_other();
        logic [7:0] c;
        c = 8'("A" + $urandom_range(25));
        if (c == CHR_H || c == CHR_T)
        begin
            c = "E";
        end
        append_char(c);
        repeat ($urandom_range(10))
        begin
            append_char(8'($urandom_range(32, 126)));
        end
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 8))
        begin
            append_char(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int quota);
        int first;
        int pick;
        first = chars_sent;
        while (chars_sent - first < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                build_text($urandom_range(9) == 0);
            end
            else if (pick < 65)
            begin
                build_header();
            end
            else if (pick < 80)
            begin
                build_broken_text();
            end
            else if (pick < 90)
            begin
                build_other();
            end
            else
            begin
                build_noise();
            end
            send_line();
        end
    endtask

    // Stop offering and wait until every predicted write has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (writes_pending == 0);
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_load(input logic [23:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin
        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short header closed by a carriage return, short text line,
        // a relocated full word with extreme bytes in the length field, a
        // non-hex digit in the tail, and a record letter that is ignored
        write_load(24'h123456);
        send_string("H 1a", 1'b0);
        send_char(CHR_CR, 1'b1);
        send_string("T12", 1'b1);
        send_string("T000000", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_string("FFFFFFFFF0G0", 1'b1);
        send_string("E", 1'b1);
        drain();

        // Sender idles often, receiver stalls more
        write_load(24'hFFFFFF);
        send_idle = 29;
        take_idle <= 67;
        run_phase(PHASE_ITEMS);
        drain();

        // Roles swapped
        write_load(24'h000000);
        send_idle = 67;
        take_idle <= 29;
        run_phase(PHASE_ITEMS);
        drain();

        // Full rate, opened by a long receiver hold against a long text line
        write_load(24'($urandom));
        send_idle = 0;
        take_idle <= 0;
        stall_epoch <= stall_epoch + 1;
        build_text(1'b1);
        send_line();
        run_phase(PHASE_ITEMS / 2);
        drain();
        run_phase(PHASE_ITEMS / 2);
        drain();

        $display("Sent %0d characters in %0d lines (%0d long text lines); %0d writes compared.",
                 chars_sent, lines_sent, long_lines, writes_checked);
        $display("Load address at zero, all ones and random; stalls on both sides and none.");
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
